/* rtl/par_pkg.sv */
// ---------------------------------------------------------------------------
// par_pkg : shared types, constants and AES helpers for the address resolver
// Holds the bond slot count, address type codes and AES round functions.
// ---------------------------------------------------------------------------
`default_nettype none
package par_pkg;

   localparam int BondSlots = 8;
   localparam int SlotW     = 3;

   localparam logic [1:0] ATYPE_PUBLIC = 2'd0;
   localparam logic [1:0] ATYPE_STATIC = 2'd1;
   localparam logic [1:0] ATYPE_RPA    = 2'd2;
   localparam logic [1:0] ATYPE_NRPA   = 2'd3;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_CONNECT = 1'b1;

   localparam int EntryW = 2 + 48 + 128;

   typedef logic [7:0] byte_type;
   typedef byte_type [15:0] block_type;

   // Launch and finish control between the sequencer and the AES core
   typedef struct packed {
      logic       start;
      logic [127:0] key;
      logic [23:0]  prand;
   } aes_req_type;

   typedef struct packed {
      logic        done;
      logic [23:0] hash;
   } aes_rsp_type;

   function automatic byte_type sbox(input byte_type x);
      byte_type t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic byte_type xtime(input byte_type x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // One cipher round on state s (index 0 is first byte), round key rk
   function automatic block_type aes_round(input block_type s, input block_type rk,
                                           input logic last);
      block_type t;
      block_type u;
      block_type o;
      for (int i = 0; i < 16; i++) t[i] = sbox(s[i]);
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) u[r + 4*c] = t[r + 4*((c + r) % 4)];
      o = u;
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            o[4*c]   = xtime(u[4*c]) ^ xtime(u[4*c+1]) ^ u[4*c+1] ^ u[4*c+2] ^ u[4*c+3];
            o[4*c+1] = u[4*c] ^ xtime(u[4*c+1]) ^ xtime(u[4*c+2]) ^ u[4*c+2] ^ u[4*c+3];
            o[4*c+2] = u[4*c] ^ u[4*c+1] ^ xtime(u[4*c+2]) ^ xtime(u[4*c+3]) ^ u[4*c+3];
            o[4*c+3] = xtime(u[4*c]) ^ u[4*c] ^ u[4*c+1] ^ u[4*c+2] ^ xtime(u[4*c+3]);
         end
      end
      for (int i = 0; i < 16; i++) o[i] = o[i] ^ rk[i];
      return o;
   endfunction

   // Next round key from the current one
   function automatic block_type key_step(input block_type k, input byte_type rcon);
      block_type n;
      n[0] = k[0] ^ sbox(k[13]) ^ rcon;
      n[1] = k[1] ^ sbox(k[14]);
      n[2] = k[2] ^ sbox(k[15]);
      n[3] = k[3] ^ sbox(k[12]);
      for (int i = 4; i < 16; i++) n[i] = k[i] ^ n[i-4];
      return n;
   endfunction

endpackage
`default_nettype wire

/* rtl/par_aes_core.sv */
// ---------------------------------------------------------------------------
// par_aes_core : round-iterative AES-128 encryption for address hashing
// One round per cycle, key schedule on the fly; returns low 24 hash bits.
// ---------------------------------------------------------------------------
`default_nettype none
module par_aes_core
   import par_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire aes_req_type aes_req,
   output aes_rsp_type      aes_rsp
);

   block_type  state_ff, state_in;
   block_type  rkey_ff, rkey_in;
   byte_type   rcon_ff, rcon_in;
   logic [3:0] round_ff, round_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   block_type  key_b;
   block_type  pt_b;
   block_type  nkey;

   // Unpack key and plaintext, most significant byte first
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         key_b[i] = aes_req.key[127 - 8*i -: 8];
         pt_b[i]  = 8'h00;
      end
      pt_b[13] = aes_req.prand[23:16];
      pt_b[14] = aes_req.prand[15:8];
      pt_b[15] = aes_req.prand[7:0];
   end

   assign nkey = key_step(rkey_ff, rcon_ff);

   // Advance one round per cycle
   always_comb begin
      state_in = state_ff;
      rkey_in  = rkey_ff;
      rcon_in  = rcon_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (aes_req.start) begin
         for (int i = 0; i < 16; i++) state_in[i] = pt_b[i] ^ key_b[i];
         rkey_in  = key_b;
         rcon_in  = 8'h01;
         round_in = 4'd1;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         state_in = aes_round(state_ff, nkey, round_ff == 4'd10);
         rkey_in  = nkey;
         rcon_in  = xtime(rcon_ff);
         round_in = round_ff + 4'd1;
         if (round_ff == 4'd10) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= 4'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         round_ff <= round_in;
      end
      state_ff <= state_in;
      rkey_ff  <= rkey_in;
      rcon_ff  <= rcon_in;
   end

   assign aes_rsp.done = done_ff;
   assign aes_rsp.hash = {state_ff[13], state_ff[14], state_ff[15]};

endmodule
`default_nettype wire

/* rtl/par_bond_ram.sv */
// ---------------------------------------------------------------------------
// par_bond_ram : bond table storage, one entry per slot
// Synchronous memory, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none
module par_bond_ram
   import par_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [SlotW-1:0]  wr_addr,
   input  wire logic [EntryW-1:0] wr_data,
   input  wire logic [SlotW-1:0]  rd_addr,
   output logic      [EntryW-1:0] rd_data
);

   logic [EntryW-1:0] mem [BondSlots];

   // Write one entry, read one entry through a registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

/* rtl/private_address_resolver.sv */
// ---------------------------------------------------------------------------
// private_address_resolver : bond table with private address resolution
// Loads bond entries and resolves connect addresses against them.
// ---------------------------------------------------------------------------
// Use: one request beat in on req_*, one response beat out on rsp_* for it.
// A write beat (op 0) loads one bond slot and its response (matched 0) is
// valid the cycle after the request is accepted. A connect beat (op 1) walks
// the slots in index order: each slot takes one bond memory read and one
// compare; a resolvable private address adds one AES-128 run per valid slot
// with a nonzero IRK. The walk stops at the first match; a connect for a
// non-resolvable private address answers unmatched without a walk.
// The slot walk runs through the bond memory read port and the round-serial
// AES core. One item is in flight at a time; the response waits in an output
// register while the receiver stalls, and req_ready stays low until it is
// taken, rising the cycle after. Reset clears the slot valid flags
// (no bonds) and the control flags of the sequencer and AES core; the other
// registers and the memory contents are left as they are.
// ---------------------------------------------------------------------------
`default_nettype none
module private_address_resolver
   import par_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic         req_op,
   input  wire logic [2:0]   req_entry_index,
   input  wire logic         req_entry_valid,
   input  wire logic [1:0]   req_addr_type,
   input  wire logic [47:0]  req_peer_address,
   input  wire logic [63:0]  req_irk_low,
   input  wire logic [63:0]  req_irk_high,
   input  wire logic [15:0]  req_conn_handle,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_matched,
   output logic [2:0]        rsp_peer_index,
   output logic [15:0]       rsp_result_handle
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_AES   = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   logic [2:0]           st_ff, st_in;
   logic [BondSlots-1:0] vld_ff, vld_in;
   logic [SlotW-1:0]     slot_ff, slot_in;
   logic [1:0]           type_ff, type_in;
   logic [47:0]          addr_ff, addr_in;
   logic                 match_ff, match_in;
   logic [SlotW-1:0]     pidx_ff, pidx_in;
   logic [15:0]          hdl_ff, hdl_in;
   logic                 wr_en;
   logic [EntryW-1:0]    rd_data;
   logic [1:0]           e_type;
   logic [47:0]          e_addr;
   logic [127:0]         e_irk;
   logic                 last_slot;
   aes_req_type          aes_req;
   aes_rsp_type          aes_rsp;

   assign req_ready = (st_ff == ST_IDLE);
   assign wr_en     = req_valid && req_ready && (req_op == OP_WRITE);
   assign e_type    = rd_data[EntryW-1 -: 2];
   assign e_addr    = rd_data[127 + 48 -: 48];
   assign e_irk     = rd_data[127:0];
   assign last_slot = (slot_ff == SlotW'(BondSlots - 1));

   par_bond_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_entry_index),
      .wr_data ({req_addr_type, req_peer_address, req_irk_high, req_irk_low}),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   assign aes_req.start = (st_ff == ST_CHECK) && vld_ff[slot_ff] && (type_ff == ATYPE_RPA)
                          && (e_irk != '0);
   assign aes_req.key   = e_irk;
   assign aes_req.prand = addr_ff[47:24];

   par_aes_core u_aes (
      .clock   (clock),
      .reset   (reset),
      .aes_req (aes_req),
      .aes_rsp (aes_rsp)
   );

   // Sequence the slot walk
   always_comb begin
      st_in    = st_ff;
      vld_in   = vld_ff;
      slot_in  = slot_ff;
      type_in  = type_ff;
      addr_in  = addr_ff;
      match_in = match_ff;
      pidx_in  = pidx_ff;
      hdl_in   = hdl_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_valid) begin
               type_in  = req_addr_type;
               addr_in  = req_peer_address;
               hdl_in   = req_conn_handle;
               match_in = 1'b0;
               pidx_in  = '0;
               slot_in  = '0;
               if (req_op == OP_WRITE) begin
                  vld_in[req_entry_index] = req_entry_valid;
                  st_in = ST_RESP;
               end else if (req_addr_type == ATYPE_NRPA) begin
                  st_in = ST_RESP;
               end else begin
                  st_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            st_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (aes_req.start) begin
               st_in = ST_AES;
            end else if (vld_ff[slot_ff] && type_ff != ATYPE_RPA
                         && e_type == type_ff && e_addr == addr_ff) begin
               match_in = 1'b1;
               pidx_in  = slot_ff;
               st_in    = ST_RESP;
            end else if (last_slot) begin
               st_in = ST_RESP;
            end else begin
               slot_in = slot_ff + 1'b1;
               st_in   = ST_READ;
            end
         end
         ST_AES: begin
            if (aes_rsp.done) begin
               if (aes_rsp.hash == addr_ff[23:0]) begin
                  match_in = 1'b1;
                  pidx_in  = slot_ff;
                  st_in    = ST_RESP;
               end else if (last_slot) begin
                  st_in = ST_RESP;
               end else begin
                  slot_in = slot_ff + 1'b1;
                  st_in   = ST_READ;
               end
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         vld_ff <= '0;
      end else begin
         st_ff  <= st_in;
         vld_ff <= vld_in;
      end
      slot_ff  <= slot_in;
      type_ff  <= type_in;
      addr_ff  <= addr_in;
      match_ff <= match_in;
      pidx_ff  <= pidx_in;
      hdl_ff   <= hdl_in;
   end

   assign rsp_valid         = (st_ff == ST_RESP);
   assign rsp_matched       = match_ff;
   assign rsp_peer_index    = pidx_ff;
   assign rsp_result_handle = hdl_ff;

endmodule
`default_nettype wire
